[rtl/qdb_pkg.sv]
// Package: word types, constants and transition decode for the quadrature decoder.
package qdb_pkg;

	localparam int unsigned POSITION_WIDTH_DEF = 32;
	localparam int unsigned TICK_W = 7;
	localparam logic [TICK_W-1:0] TICK_MAX = 7'd127;
	localparam logic [TICK_W-1:0] DEBOUNCE_RST = 7'd50;

	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_UP   = 2'd1;
	localparam logic [1:0] DIR_DOWN = 2'd2;

	typedef struct packed {
		logic               enc_a;
		logic               enc_b;
		logic               switch_level;
		logic               load_position;
		logic signed [31:0] new_position;
		logic               ack_button;
	} qdb_in_t;

	typedef struct packed {
		logic signed [31:0] position;
		logic               button_pressed;
	} qdb_out_t;

	typedef struct packed {
		logic [1:0]        last_code;
		logic              primed;
		logic              last_switch;
		logic [TICK_W-1:0] ticks;
		logic              flag;
	} qdb_ctl_t;

	function automatic logic [1:0] quad_dir(input logic [1:0] old_code,
	                                        input logic [1:0] new_code);
		logic [1:0] dir;
		dir = DIR_NONE;
		case ({old_code, new_code})
			4'h1, 4'h7, 4'hE, 4'h8: dir = DIR_UP;
			4'h2, 4'h4, 4'hD, 4'hB: dir = DIR_DOWN;
			default:                dir = DIR_NONE;
		endcase
		return dir;
	endfunction

endpackage

[rtl/qdb_step.sv]
// Step logic: decodes one poll tick against the current state.
module qdb_step #(
	parameter int unsigned POSITION_WIDTH = qdb_pkg::POSITION_WIDTH_DEF
) (
	input  qdb_pkg::qdb_in_t           word,
	input  logic [POSITION_WIDTH-1:0]  pos_cur,
	input  qdb_pkg::qdb_ctl_t          ctl_cur,
	input  logic [qdb_pkg::TICK_W-1:0] debounce,
	output logic [POSITION_WIDTH-1:0]  pos_nxt,
	output qdb_pkg::qdb_ctl_t          ctl_nxt,
	output qdb_pkg::qdb_out_t          result
);
	import qdb_pkg::*;

	logic [POSITION_WIDTH+31:0] load_ext;
	logic [POSITION_WIDTH+31:0] out_ext;
	logic [POSITION_WIDTH-1:0]  pos_base;
	logic [1:0]                 code;
	logic [1:0]                 dir;
	logic [TICK_W-1:0]          ticks_inc;
	logic                       edge_hit;
	logic                       flag_rep;

	assign code      = {word.enc_a, word.enc_b};
	assign load_ext  = {{POSITION_WIDTH{word.new_position[31]}}, word.new_position};
	assign pos_base  = word.load_position ? load_ext[POSITION_WIDTH-1:0] : pos_cur;
	assign dir       = quad_dir(ctl_cur.last_code, code);
	assign ticks_inc = (ctl_cur.ticks == TICK_MAX) ? TICK_MAX : ctl_cur.ticks + 1'b1;

	always_comb begin
		ctl_nxt  = ctl_cur;
		pos_nxt  = pos_base;
		edge_hit = 1'b0;
		ctl_nxt.primed    = 1'b1;
		ctl_nxt.last_code = code;
		if (!ctl_cur.primed) begin
			ctl_nxt.last_switch = word.switch_level;
		end else begin
			case (dir)
				DIR_UP:   pos_nxt = pos_base + 1'b1;
				DIR_DOWN: pos_nxt = pos_base - 1'b1;
				default:  pos_nxt = pos_base;
			endcase
			ctl_nxt.ticks = ticks_inc;
			if (word.switch_level != ctl_cur.last_switch) begin
				edge_hit            = word.switch_level && (ticks_inc > debounce);
				ctl_nxt.ticks       = '0;
				ctl_nxt.last_switch = word.switch_level;
			end
		end
		flag_rep     = ctl_cur.flag | edge_hit;
		ctl_nxt.flag = (word.ack_button && !edge_hit) ? 1'b0 : flag_rep;
	end

	assign out_ext               = {32'd0, pos_nxt};
	assign result.position       = out_ext[31:0];
	assign result.button_pressed = flag_rep;

endmodule

[rtl/quadrature_decoder_with_button.sv]
// Top level: x4 quadrature decoder with debounced push-button press flag.
//
// Input channel: in_valid/in_ready carry one poll-tick word (A/B levels,
// switch level, optional position load, optional flag acknowledge).
// Output channel: out_valid/out_ready carry one result word per tick: the
// position after the tick and the press flag before the acknowledge.
// Configuration: cfg_we writes cfg_wdata into the debounce tick count; write
// it only while no word is in flight.
// Path: an accepted word lands in the input register, then its result is
// registered in the result register and appears on out_word.
// Throughput: one word per cycle while out_ready is high; the decode and
// add are combinational between the input register and the result register.
// Reset: position, code and switch history clear, the tick counter starts
// saturated at 127, the press flag clears, debounce returns to 50. The first
// tick after reset only captures levels and applies any position load.
// Stall: when out_ready is low the result word holds; the input register
// still takes one more word, after which in_ready follows out_ready.
module quadrature_decoder_with_button #(
	parameter int unsigned POSITION_WIDTH = qdb_pkg::POSITION_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  qdb_pkg::qdb_in_t           in_word,
	output logic                       out_valid,
	input  logic                       out_ready,
	output qdb_pkg::qdb_out_t          out_word,
	input  logic                       cfg_we,
	input  logic [qdb_pkg::TICK_W-1:0] cfg_wdata
);
	import qdb_pkg::*;

	qdb_in_t                   word_s1;
	logic                      valid_s1;
	qdb_out_t                  res_q;
	logic                      res_valid_q;
	logic [POSITION_WIDTH-1:0] pos_q;
	logic [POSITION_WIDTH-1:0] pos_nxt;
	qdb_ctl_t                  ctl_q;
	qdb_ctl_t                  ctl_nxt;
	qdb_out_t                  result;
	logic [TICK_W-1:0]         debounce_q;
	logic                      advance;

	assign advance   = valid_s1 && (!res_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = res_valid_q;
	assign out_word  = res_q;

	qdb_step #(
		.POSITION_WIDTH(POSITION_WIDTH)
	) u_step (
		.word    (word_s1),
		.pos_cur (pos_q),
		.ctl_cur (ctl_q),
		.debounce(debounce_q),
		.pos_nxt (pos_nxt),
		.ctl_nxt (ctl_nxt),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
		end else if (cfg_we) begin
			debounce_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= result;
		end
	end

	// advance state once per decoded tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q             <= '0;
			ctl_q.last_code   <= '0;
			ctl_q.primed      <= 1'b0;
			ctl_q.last_switch <= 1'b0;
			ctl_q.ticks       <= TICK_MAX;
			ctl_q.flag        <= 1'b0;
		end else if (advance) begin
			pos_q <= pos_nxt;
			ctl_q <= ctl_nxt;
		end
	end

endmodule

[rtl/qdb_checker.sv]
// Checker: port-level properties of the quadrature decoder, bound to the top level.
module qdb_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input qdb_pkg::qdb_out_t          out_word
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("accepted word produced no result within two cycles");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && out_valid && !out_ready |=> in_ready == out_ready)
		else $error("input ready does not follow output ready with full pipeline");

endmodule

bind quadrature_decoder_with_button qdb_checker u_qdb_checker (.*);

[bench/tb_top.sv]
// Testbench for the quadrature decoder: directed tick table, random encoder traffic, checks.
module tb_top;
	import qdb_pkg::*;

	localparam int LONG_HOLD      = 80;
	localparam int PHASE_ITEMS    = 90;
	localparam int PHASES         = 7;
	localparam int TAIL_CYCLES    = 8;
	localparam int WATCHDOG_LIMIT = 1000;

	typedef struct {
		bit                cfg_now;
		logic [TICK_W-1:0] cfg_val;
		bit                typed;
		qdb_in_t           word;
		qdb_out_t          want;
	} tick_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	qdb_in_t           in_word = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	qdb_out_t          out_word;
	logic              cfg_we = 1'b0;
	logic [TICK_W-1:0] cfg_wdata = '0;

	logic signed [31:0] m_pos = '0;
	logic [1:0]         m_code = '0;
	logic               m_primed = 1'b0;
	logic               m_sw = 1'b0;
	logic [TICK_W-1:0]  m_ticks = TICK_MAX;
	logic               m_flag = 1'b0;
	logic [TICK_W-1:0]  m_debounce = DEBOUNCE_RST;

	qdb_out_t  pending_results[$];
	tick_row_t tick_table[$];
	int        errors = 0;
	int        idle_cycles = 0;
	int        gap_pct = 0;
	int        stall_pct = 0;
	bit        hold_req = 1'b0;
	int        hold_left = 0;

	quadrature_decoder_with_button u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [1:0] gray_fwd(input logic [1:0] code);
		case (code)
			2'd0:    return 2'd1;
			2'd1:    return 2'd3;
			2'd3:    return 2'd2;
			default: return 2'd0;
		endcase
	endfunction

	function automatic logic [1:0] gray_back(input logic [1:0] code);
		case (code)
			2'd0:    return 2'd2;
			2'd2:    return 2'd3;
			2'd3:    return 2'd1;
			default: return 2'd0;
		endcase
	endfunction

	function automatic int idle_len();
		return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 25);
	endfunction

	function automatic qdb_out_t decode_tick(input qdb_in_t w);
		logic [1:0] code;
		logic [1:0] dir;
		logic       rise;
		qdb_out_t   res;
		code = {w.enc_a, w.enc_b};
		rise = 1'b0;
		if (w.load_position)
			m_pos = w.new_position;
		if (!m_primed) begin
			m_primed = 1'b1;
			m_code = code;
			m_sw = w.switch_level;
		end else begin
			if (code == gray_fwd(m_code))
				dir = DIR_UP;
			else if (code == gray_back(m_code))
				dir = DIR_DOWN;
			else
				dir = DIR_NONE;
			if (dir == DIR_UP)
				m_pos = m_pos + 32'sd1;
			else if (dir == DIR_DOWN)
				m_pos = m_pos - 32'sd1;
			m_code = code;
			if (m_ticks != TICK_MAX)
				m_ticks = m_ticks + 1'b1;
			if (w.switch_level != m_sw) begin
				rise = w.switch_level && (m_ticks > m_debounce);
				m_ticks = '0;
				m_sw = w.switch_level;
			end
		end
		if (rise)
			m_flag = 1'b1;
		res.position = m_pos;
		res.button_pressed = m_flag;
		if (w.ack_button && !rise)
			m_flag = 1'b0;
		return res;
	endfunction

	function automatic void add_row(input bit cfg_now, input int cfg_val, input bit typed,
	                                input bit a, input bit b, input bit sw, input bit ld,
	                                input logic [31:0] val, input bit ack,
	                                input logic [31:0] want_pos, input bit want_flag);
		tick_row_t r;
		r.cfg_now = cfg_now;
		r.cfg_val = cfg_val[TICK_W-1:0];
		r.typed = typed;
		r.word.enc_a = a;
		r.word.enc_b = b;
		r.word.switch_level = sw;
		r.word.load_position = ld;
		r.word.new_position = val;
		r.word.ack_button = ack;
		r.want.position = want_pos;
		r.want.button_pressed = want_flag;
		tick_table.push_back(r);
	endfunction

	task automatic send_tick(input qdb_in_t w, input bit typed, input qdb_out_t want);
		int       gap;
		qdb_out_t pred;
		gap = 0;
		if (hold_left == 0 && $urandom_range(0, 99) < gap_pct)
			gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (!in_ready);
		pred = decode_tick(w);
		pending_results.push_back(typed ? want : pred);
	endtask

	task automatic set_debounce(input logic [TICK_W-1:0] val);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		m_debounce = val;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, idle_cycles);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		qdb_out_t want;
		int       stall_left;
		bit       hold_done;
		stall_left = 0;
		hold_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: expected none, got %h", $time, out_word);
				end else begin
					want = pending_results.pop_front();
					if (out_word.position !== want.position) begin
						errors++;
						$display("%0t: position: expected %h, got %h",
						         $time, want.position, out_word.position);
					end
					if (out_word.button_pressed !== want.button_pressed) begin
						errors++;
						$display("%0t: button_pressed: expected %b, got %b",
						         $time, want.button_pressed, out_word.button_pressed);
					end
				end
			end
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 99) < stall_pct) begin
				stall_left = idle_len() - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		qdb_in_t    w;
		int         debounce_plan[PHASES];
		int         pick;
		int         sw_run;
		logic [1:0] gen_code;
		logic       gen_sw;

		add_row(0,   0, 1, 1, 1, 0, 1, 32'h0000_0100, 1, 32'h0000_0100, 0);
		add_row(0,   0, 0, 1, 0, 1, 0, 32'h0,         0, 32'h0,         0);
		add_row(0,   0, 0, 0, 0, 1, 0, 32'h0,         1, 32'h0,         0);
		add_row(0,   0, 0, 0, 1, 1, 0, 32'h0,         0, 32'h0,         0);
		add_row(0,   0, 0, 1, 1, 0, 0, 32'h0,         0, 32'h0,         0);
		add_row(0,   0, 0, 0, 0, 1, 0, 32'h0,         1, 32'h0,         0);
		add_row(0,   0, 0, 1, 0, 1, 0, 32'h0,         0, 32'h0,         0);
		add_row(0,   0, 0, 1, 1, 1, 0, 32'h0,         0, 32'h0,         0);
		add_row(0,   0, 0, 0, 1, 1, 0, 32'h0,         0, 32'h0,         0);
		add_row(0,   0, 0, 0, 0, 1, 0, 32'h0,         0, 32'h0,         0);
		add_row(0,   0, 1, 0, 1, 1, 1, 32'h7FFF_FFFF, 0, 32'h8000_0000, 0);
		add_row(0,   0, 1, 0, 0, 1, 1, 32'h8000_0000, 0, 32'h7FFF_FFFF, 0);
		add_row(0,   0, 1, 1, 0, 1, 1, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFE, 0);
		add_row(0,   0, 1, 1, 0, 1, 1, 32'h0000_0000, 0, 32'h0000_0000, 0);
		add_row(1,   0, 0, 1, 0, 0, 0, 32'h0,         0, 32'h0,         0);
		add_row(0,   0, 0, 1, 0, 1, 0, 32'h0,         1, 32'h0,         0);
		add_row(0,   0, 0, 1, 0, 1, 0, 32'h0,         1, 32'h0,         0);
		add_row(0,   0, 0, 1, 0, 1, 0, 32'h0,         0, 32'h0,         0);
		add_row(1, 127, 0, 1, 1, 0, 0, 32'h0,         0, 32'h0,         0);
		add_row(0,   0, 0, 0, 1, 1, 0, 32'h0,         0, 32'h0,         0);
		add_row(1, 100, 0, 0, 1, 1, 1, 32'h1234_5678, 1, 32'h0,         0);
		add_row(0,   0, 0, 1, 1, 0, 0, 32'h0,         0, 32'h0,         0);

		debounce_plan = '{0, 2, 127, 100, 8, 20, 0};
		debounce_plan[PHASES-1] = $urandom_range(0, 100);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		gap_pct = 20;
		stall_pct = 20;
		foreach (tick_table[i]) begin
			if (tick_table[i].cfg_now)
				set_debounce(tick_table[i].cfg_val);
			send_tick(tick_table[i].word, tick_table[i].typed, tick_table[i].want);
		end

		gen_code = {tick_table[tick_table.size()-1].word.enc_a,
		            tick_table[tick_table.size()-1].word.enc_b};
		gen_sw = tick_table[tick_table.size()-1].word.switch_level;
		sw_run = 0;
		for (int ph = 0; ph < PHASES; ph++) begin
			set_debounce(TICK_W'(debounce_plan[ph]));
			gap_pct = (ph % 3 == 0) ? 0 : $urandom_range(5, 50);
			stall_pct = (ph % 3 == 2) ? 0 : $urandom_range(5, 50);
			if (ph == 1)
				hold_req = 1'b1;
			repeat (PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 45)
					gen_code = gray_fwd(gen_code);
				else if (pick < 80)
					gen_code = gray_back(gen_code);
				else if (pick >= 92)
					gen_code = 2'($urandom_range(0, 3));
				if (sw_run == 0) begin
					gen_sw = ~gen_sw;
					if ($urandom_range(0, 3) == 0)
						sw_run = $urandom_range(1, 3);
					else
						sw_run = $urandom_range(debounce_plan[ph] / 2 + 1,
						                        debounce_plan[ph] + 12);
				end else begin
					sw_run--;
				end
				w.enc_a = gen_code[1];
				w.enc_b = gen_code[0];
				w.switch_level = gen_sw;
				w.load_position = ($urandom_range(0, 24) == 0);
				case ($urandom_range(0, 7))
					0:       w.new_position = 32'h7FFF_FFFF;
					1:       w.new_position = 32'h8000_0000;
					2:       w.new_position = 32'hFFFF_FFFF;
					default: w.new_position = $urandom;
				endcase
				w.ack_button = ($urandom_range(0, 3) == 0);
				send_tick(w, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[filelist.f]
rtl/qdb_pkg.sv
rtl/qdb_step.sv
rtl/quadrature_decoder_with_button.sv
rtl/qdb_checker.sv
bench/tb_top.sv
